/* rtl/pcmd_pkg.sv */
// ----------------------------------------------------------------------------
// pcmd_pkg
// Types and constants for the pulse-count command motor drive core.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmd_pkg;

    localparam int PWM_PERIOD = 100;
    localparam int MAX_PULSES = 15;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int SAMPLE_W = 10;
    localparam int GAP_W    = 8;
    localparam int DUTY_W   = 7;
    localparam int WORD_W   = 4;
    localparam int PWM_W    = 7;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_GAP_LIMIT      = 2'd2;
    localparam logic [1:0] REG_FULL_DUTY      = 2'd3;

    localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = SAMPLE_W'(310);
    localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = SAMPLE_W'(465);
    localparam logic [GAP_W-1:0]    GAP_LIMIT_RST      = GAP_W'(30);
    localparam logic [DUTY_W-1:0]   FULL_DUTY_RST      = DUTY_W'(100);

    // command words
    localparam logic [WORD_W-1:0] CMD_LEFT    = WORD_W'(5);
    localparam logic [WORD_W-1:0] CMD_RIGHT   = WORD_W'(4);
    localparam logic [WORD_W-1:0] CMD_REVERSE = WORD_W'(3);
    localparam logic [WORD_W-1:0] CMD_FORWARD = WORD_W'(2);

    typedef enum logic [1:0] {
        SIDE_REVERSE,
        SIDE_FORWARD,
        SIDE_BRAKE
    } side_mode_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic                gap_tick;
        logic                pwm_tick;
    } sample_t;

    typedef struct packed {
        logic              left_fwd_pin;
        logic              left_back_pin;
        logic              right_fwd_pin;
        logic              right_back_pin;
        logic              command_applied;
        logic [WORD_W-1:0] applied_command;
    } drive_t;

endpackage

`default_nettype wire

/* rtl/pulse_count_command_motor_drive_core.sv */
// ----------------------------------------------------------------------------
// pulse_count_command_motor_drive_core
// Pulse-count command decoder with four-pin PWM motor drive.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one ADC
//   reading with gap and PWM tick strobes per transfer. drive channel
//   (drive_valid / drive_stall / drive) returns one result per transfer:
//   four pin levels, the applied-command flag and the last applied word.
//   The result of a transfer is valid in the next cycle. Throughput is
//   one transfer per cycle while the receiver does not stall; the decoder
//   state and the PWM counter update in a single pass of compare/count logic.
//   When the receiver stalls, the result register holds and sample_stall is
//   raised in the same cycle, so no transfer is lost; a result that is being
//   taken frees the register for a new transfer in that same cycle.
//   Reset clears the decoder, the duties and the PWM counter, loads the
//   register defaults (310, 465, 30, 100) and empties the result register.
//   Registers are written over APB at byte addresses 0, 4, 8, 12.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_count_command_motor_drive_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           sample_valid,
    output      logic                           sample_stall,
    input  wire pcmd_pkg::sample_t              sample,

    output      logic                           drive_valid,
    input  wire logic                           drive_stall,
    output      pcmd_pkg::drive_t               drive,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pcmd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [pcmd_pkg::DATA_W-1:0]    pwdata,
    output      logic [pcmd_pkg::DATA_W-1:0]    prdata,
    output      logic                           pready
);

    localparam int SW = pcmd_pkg::SAMPLE_W;
    localparam int GW = pcmd_pkg::GAP_W;
    localparam int DW = pcmd_pkg::DUTY_W;
    localparam int WW = pcmd_pkg::WORD_W;
    localparam int PW = pcmd_pkg::PWM_W;

    logic [SW-1:0] low_threshold_reg;
    logic [SW-1:0] high_threshold_reg;
    logic [GW-1:0] gap_limit_reg;
    logic [DW-1:0] full_duty_reg;

    logic          phase_low_reg,     phase_low_next;
    logic [GW-1:0] gap_count_reg,     gap_count_next;
    logic [WW-1:0] pulse_count_reg,   pulse_count_next;
    logic [WW-1:0] previous_word_reg, previous_word_next;
    logic [PW-1:0] pwm_count_reg,     pwm_count_next;
    logic [DW-1:0] duty_reg [4];
    logic [DW-1:0] duty_next [4];
    logic [WW-1:0] last_applied_reg,  last_applied_next;
    logic          drive_valid_reg,   drive_valid_next;
    pcmd_pkg::drive_t drive_reg,      drive_next;

    logic          accept;
    logic          cfg_write;
    logic [1:0]    cfg_index;
    logic [GW-1:0] gap_bumped;
    logic [WW-1:0] pulse_bumped;
    logic          applied;
    pcmd_pkg::side_mode_t left_mode;
    pcmd_pkg::side_mode_t right_mode;

    assign sample_stall = drive_valid_reg & drive_stall;
    assign accept       = sample_valid & ~sample_stall;
    assign drive_valid  = drive_valid_reg;
    assign drive        = drive_reg;
    assign pready       = 1'b1;
    assign cfg_write    = psel & penable & pwrite;
    assign cfg_index    = paddr[3:2];

    always_comb
    begin
        case (cfg_index)
            pcmd_pkg::REG_LOW_THRESHOLD:  prdata = pcmd_pkg::DATA_W'(low_threshold_reg);
            pcmd_pkg::REG_HIGH_THRESHOLD: prdata = pcmd_pkg::DATA_W'(high_threshold_reg);
            pcmd_pkg::REG_GAP_LIMIT:      prdata = pcmd_pkg::DATA_W'(gap_limit_reg);
            pcmd_pkg::REG_FULL_DUTY:      prdata = pcmd_pkg::DATA_W'(full_duty_reg);
            default:                      prdata = '0;
        endcase
    end

    always_comb
    begin
        gap_bumped = gap_count_reg;
        if (sample.gap_tick && (gap_count_reg != {GW{1'b1}}))
        begin
            gap_bumped = gap_count_reg + GW'(1);
        end
        pulse_bumped = (pulse_count_reg >= WW'(pcmd_pkg::MAX_PULSES))
                     ? WW'(pcmd_pkg::MAX_PULSES) : pulse_count_reg + WW'(1);
    end

    always_comb
    begin
        phase_low_next     = phase_low_reg;
        gap_count_next     = gap_count_reg;
        pulse_count_next   = pulse_count_reg;
        previous_word_next = previous_word_reg;
        applied            = 1'b0;

        if (!phase_low_reg)
        begin
            if (sample.adc_sample <= low_threshold_reg)
            begin
                phase_low_next = 1'b1;
            end
        end
        else
        begin
            gap_count_next = gap_bumped;
            if (sample.adc_sample >= high_threshold_reg)
            begin
                pulse_count_next = pulse_bumped;
                if (gap_bumped > gap_limit_reg)
                begin
                    applied            = (pulse_bumped == previous_word_reg);
                    previous_word_next = pulse_bumped;
                    pulse_count_next   = '0;
                end
                gap_count_next = '0;
                phase_low_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        case (pulse_bumped)
            pcmd_pkg::CMD_LEFT:
            begin
                left_mode  = pcmd_pkg::SIDE_FORWARD;
                right_mode = pcmd_pkg::SIDE_BRAKE;
            end
            pcmd_pkg::CMD_RIGHT:
            begin
                left_mode  = pcmd_pkg::SIDE_BRAKE;
                right_mode = pcmd_pkg::SIDE_FORWARD;
            end
            pcmd_pkg::CMD_REVERSE:
            begin
                left_mode  = pcmd_pkg::SIDE_REVERSE;
                right_mode = pcmd_pkg::SIDE_REVERSE;
            end
            pcmd_pkg::CMD_FORWARD:
            begin
                left_mode  = pcmd_pkg::SIDE_FORWARD;
                right_mode = pcmd_pkg::SIDE_FORWARD;
            end
            default:
            begin
                left_mode  = pcmd_pkg::SIDE_BRAKE;
                right_mode = pcmd_pkg::SIDE_BRAKE;
            end
        endcase

        duty_next         = duty_reg;
        last_applied_next = last_applied_reg;
        if (applied)
        begin
            duty_next[0] = (left_mode == pcmd_pkg::SIDE_REVERSE)  ? '0 : full_duty_reg;
            duty_next[1] = (left_mode == pcmd_pkg::SIDE_FORWARD)  ? '0 : full_duty_reg;
            duty_next[2] = (right_mode == pcmd_pkg::SIDE_REVERSE) ? '0 : full_duty_reg;
            duty_next[3] = (right_mode == pcmd_pkg::SIDE_FORWARD) ? '0 : full_duty_reg;
            last_applied_next = pulse_bumped;
        end
    end

    always_comb
    begin
        pwm_count_next = pwm_count_reg;
        if (sample.pwm_tick)
        begin
            if (pwm_count_reg >= PW'(pcmd_pkg::PWM_PERIOD))
            begin
                pwm_count_next = PW'(1);
            end
            else
            begin
                pwm_count_next = pwm_count_reg + PW'(1);
            end
        end

        drive_next.left_fwd_pin    = (pwm_count_next <= duty_next[0]);
        drive_next.left_back_pin   = (pwm_count_next <= duty_next[1]);
        drive_next.right_fwd_pin   = (pwm_count_next <= duty_next[2]);
        drive_next.right_back_pin  = (pwm_count_next <= duty_next[3]);
        drive_next.command_applied = applied;
        drive_next.applied_command = last_applied_next;

        drive_valid_next = drive_valid_reg;
        if (accept)
        begin
            drive_valid_next = 1'b1;
        end
        else if (!drive_stall)
        begin
            drive_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_threshold_reg  <= pcmd_pkg::LOW_THRESHOLD_RST;
            high_threshold_reg <= pcmd_pkg::HIGH_THRESHOLD_RST;
            gap_limit_reg      <= pcmd_pkg::GAP_LIMIT_RST;
            full_duty_reg      <= pcmd_pkg::FULL_DUTY_RST;
            phase_low_reg      <= 1'b0;
            gap_count_reg      <= '0;
            pulse_count_reg    <= '0;
            previous_word_reg  <= '0;
            pwm_count_reg      <= '0;
            duty_reg           <= '{default: '0};
            last_applied_reg   <= '0;
            drive_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    pcmd_pkg::REG_LOW_THRESHOLD:  low_threshold_reg  <= pwdata[SW-1:0];
                    pcmd_pkg::REG_HIGH_THRESHOLD: high_threshold_reg <= pwdata[SW-1:0];
                    pcmd_pkg::REG_GAP_LIMIT:      gap_limit_reg      <= pwdata[GW-1:0];
                    pcmd_pkg::REG_FULL_DUTY:      full_duty_reg      <= pwdata[DW-1:0];
                    default:                      ;
                endcase
            end
            if (accept)
            begin
                phase_low_reg     <= phase_low_next;
                gap_count_reg     <= gap_count_next;
                pulse_count_reg   <= pulse_count_next;
                previous_word_reg <= previous_word_next;
                pwm_count_reg     <= pwm_count_next;
                duty_reg          <= duty_next;
                last_applied_reg  <= last_applied_next;
            end
            drive_valid_reg <= drive_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg <= drive_next;
        end
    end

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> drive_valid_reg)
        else $error("accepted transfer produced no result");

    a_gap_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_low_reg |-> (gap_count_reg == '0))
        else $error("gap counter nonzero outside low phase");

    a_pwm_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pwm_count_reg <= PW'(pcmd_pkg::PWM_PERIOD))
        else $error("pwm counter beyond period");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |=> ($stable(drive_reg) && drive_valid_reg))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
